/* design/mks_pkg.sv */
// Package for the Morse keying sequencer: sizes, segment kinds, the element
// table and the character lookup. Used by the interfaces, the top level and
// its checker.
package mks_pkg;

  // Most elements sent per character.
  localparam int MAX_ELEMENTS = 6;
  // Width of the saturating unsent-character counter.
  localparam int COUNT_WIDTH  = 16;

  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 3;
  localparam int TICK_W   = 16;
  localparam int DUR_W    = 19;
  localparam int SHOWN_W  = 16;
  localparam int ROW_W    = 6;
  localparam int ROWS     = 39;
  localparam int ROW_IDX_W = $clog2(ROWS);
  localparam int TLEN_W   = 3;
  localparam int LEN_W    = $clog2(MAX_ELEMENTS + 1);

  localparam logic [TICK_W-1:0] DOT_TICKS_RST = 16'd50;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_A     = 8'd65;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'd90;
  localparam logic [CHAR_W-1:0] CH_0     = 8'd48;
  localparam logic [CHAR_W-1:0] CH_9     = 8'd57;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'd59;

  localparam logic [ROW_IDX_W-1:0] ROW_DIGIT0 = 6'd26;
  localparam logic [ROW_IDX_W-1:0] ROW_DOT    = 6'd36;
  localparam logic [ROW_IDX_W-1:0] ROW_COMMA  = 6'd37;
  localparam logic [ROW_IDX_W-1:0] ROW_SEMI   = 6'd38;

  typedef enum logic [KIND_W-1:0] {
    SEG_DOT         = 3'd0,
    SEG_DASH        = 3'd1,
    SEG_ELEM_GAP    = 3'd2,
    SEG_LETTER_GAP  = 3'd3,
    SEG_WORD_GAP    = 3'd4,
    SEG_UNKNOWN_GAP = 3'd5
  } seg_kind_t;

  // Row entry: {length, pattern}; pattern bit j is 1 when element j is a dash.
  localparam logic [TLEN_W+ROW_W-1:0] CODE_ROWS [ROWS] = '{
    {3'd2, 6'b000010}, {3'd4, 6'b000001}, {3'd4, 6'b000101}, {3'd3, 6'b000001},
    {3'd1, 6'b000000}, {3'd4, 6'b000100}, {3'd3, 6'b000011}, {3'd4, 6'b000000},
    {3'd2, 6'b000000}, {3'd4, 6'b001110}, {3'd3, 6'b000101}, {3'd4, 6'b000010},
    {3'd2, 6'b000011}, {3'd2, 6'b000001}, {3'd3, 6'b000111}, {3'd4, 6'b000110},
    {3'd4, 6'b001011}, {3'd3, 6'b000010}, {3'd3, 6'b000000}, {3'd1, 6'b000001},
    {3'd3, 6'b000100}, {3'd4, 6'b001000}, {3'd3, 6'b000110}, {3'd4, 6'b001001},
    {3'd4, 6'b001101}, {3'd4, 6'b000011},
    {3'd5, 6'b011111}, {3'd5, 6'b011110}, {3'd5, 6'b011100}, {3'd5, 6'b011000},
    {3'd5, 6'b010000}, {3'd5, 6'b000000}, {3'd5, 6'b000001}, {3'd5, 6'b000011},
    {3'd5, 6'b000111}, {3'd5, 6'b001111},
    {3'd6, 6'b101010}, {3'd6, 6'b110011}, {3'd6, 6'b010101}
  };

  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] len;
    logic [ROW_W-1:0] pat;
  } row_t;

  // Map a character to its table row; length clipped to MAX_ELEMENTS.
  function automatic row_t lookup_row(input logic [CHAR_W-1:0] c);
    row_t                          r;
    logic [ROW_IDX_W-1:0]          idx;
    logic [TLEN_W+ROW_W-1:0]       ent;
    logic [TLEN_W-1:0]             tlen;
    r   = '0;
    idx = '0;
    if (c >= CH_A && c <= CH_Z) begin
      r.hit = 1'b1;
      idx   = ROW_IDX_W'(c - CH_A);
    end else if (c >= CH_0 && c <= CH_9) begin
      r.hit = 1'b1;
      idx   = ROW_DIGIT0 + ROW_IDX_W'(c - CH_0);
    end else if (c == CH_DOT) begin
      r.hit = 1'b1;
      idx   = ROW_DOT;
    end else if (c == CH_COMMA) begin
      r.hit = 1'b1;
      idx   = ROW_COMMA;
    end else if (c == CH_SEMI) begin
      r.hit = 1'b1;
      idx   = ROW_SEMI;
    end
    ent  = CODE_ROWS[idx];
    tlen = ent[TLEN_W+ROW_W-1:ROW_W];
    r.pat = ent[ROW_W-1:0];
    if (32'(tlen) > MAX_ELEMENTS) begin
      r.len = LEN_W'(MAX_ELEMENTS);
    end else begin
      r.len = LEN_W'(tlen);
    end
    return r;
  endfunction

endpackage

/* design/mks_if.sv */
// Channel interfaces for the Morse keying sequencer: character input,
// segment output and the unit-length configuration write.
// Depends on mks_pkg for field widths.

interface mks_in_if;
  import mks_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface mks_out_if;
  import mks_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  segment_kind;
  logic               key_on;
  logic [DUR_W-1:0]   duration_ticks;
  logic [SHOWN_W-1:0] unsent_count;
  logic               last;
  modport source (output valid, output segment_kind, output key_on,
                  output duration_ticks, output unsent_count, output last,
                  input ready);
  modport sink   (input valid, input segment_kind, input key_on,
                  input duration_ticks, input unsent_count, input last,
                  output ready);
endinterface

interface mks_cfg_if;
  import mks_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/morse_keying_sequencer_top.sv */
// Morse keying sequencer top level: lookup, segment sequencer and output
// register. Depends on mks_pkg and the channel interfaces in mks_if.sv.
//
// One character is taken per transfer on in_ch and turned into timed keying
// segments on out_ch, one segment per cycle while out_ch is ready. A character
// that yields n segments (1 for space or an unknown code, up to 12 for a
// six-element mark) is accepted and its row looked up, then the sequencer
// issues them in turn; in_ch stays not ready until the last one is issued.
// The sequencer's single shift-and-add unit forms each duration (1, 3 or 5
// times dot_ticks). Output stalls hold the sequencer. The last segment sits in
// the output register while the next character is accepted. dot_ticks is
// written through cfg_ch (always ready) and resets to 50.

module morse_keying_sequencer_top (
  input  logic clk,
  input  logic rst_n,
  mks_in_if.sink    in_ch,
  mks_out_if.source out_ch,
  mks_cfg_if.sink   cfg_ch
);
  import mks_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TICK_W-1:0]      dot_r;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [ROW_W-1:0]       pat_r, pat_nxt;
  logic [LEN_W-1:0]       rem_r, rem_nxt;
  logic                   gap_r, gap_nxt;
  logic                   single_r, single_nxt;
  seg_kind_t              single_kind_r, single_kind_nxt;

  logic                   out_valid_r, out_valid_nxt;
  seg_kind_t              kind_r;
  logic                   key_on_r;
  logic [DUR_W-1:0]       dur_r;
  logic [SHOWN_W-1:0]     shown_r;
  logic                   last_r;

  logic                   in_fire;
  logic                   gen;
  row_t                   row;
  seg_kind_t              seg_kind;
  logic                   seg_last;
  logic [DUR_W-1:0]       addend;
  logic [DUR_W-1:0]       seg_dur;
  logic [31:0]            cnt_ext;
  logic [SHOWN_W-1:0]     shown;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign gen          = (state_r == S_RUN) && (!out_valid_r || out_ch.ready);
  assign row          = lookup_row(in_ch.char_code);

  // Pick the next segment from the sequencer state.
  always_comb begin
    seg_kind = SEG_LETTER_GAP;
    seg_last = 1'b0;
    if (single_r) begin
      seg_kind = single_kind_r;
      seg_last = 1'b1;
    end else if (gap_r) begin
      seg_kind = SEG_ELEM_GAP;
    end else if (rem_r != '0) begin
      seg_kind = pat_r[0] ? SEG_DASH : SEG_DOT;
    end else begin
      seg_kind = SEG_LETTER_GAP;
      seg_last = 1'b1;
    end
  end

  // Shared duration unit: dot_ticks plus 0, 2x or 4x dot_ticks.
  always_comb begin
    unique case (seg_kind) inside
      SEG_DASH, SEG_LETTER_GAP:      addend = DUR_W'({dot_r, 1'b0});
      SEG_WORD_GAP, SEG_UNKNOWN_GAP: addend = DUR_W'({dot_r, 2'b00});
      default:                       addend = '0;
    endcase
    seg_dur = DUR_W'(dot_r) + addend;
  end

  // Report the counter, clipped to the field width.
  assign cnt_ext = 32'(cnt_r);
  assign shown   = (cnt_ext > 32'(16'hFFFF)) ? 16'hFFFF : cnt_ext[SHOWN_W-1:0];

  // Sequencer: load on accept, advance one segment per issue.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pat_nxt         = pat_r;
    rem_nxt         = rem_r;
    gap_nxt         = gap_r;
    single_nxt      = single_r;
    single_kind_nxt = single_kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_RUN;
          pat_nxt   = row.pat;
          rem_nxt   = row.len;
          gap_nxt   = 1'b0;
          if (in_ch.char_code == CH_SPACE) begin
            single_nxt      = 1'b1;
            single_kind_nxt = SEG_WORD_GAP;
          end else if (!row.hit) begin
            single_nxt      = 1'b1;
            single_kind_nxt = SEG_UNKNOWN_GAP;
            if (cnt_r != {COUNT_WIDTH{1'b1}}) begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end else begin
            single_nxt = 1'b0;
          end
        end
      end
      S_RUN: begin
        if (gen) begin
          if (seg_last) begin
            state_nxt  = S_IDLE;
            single_nxt = 1'b0;
          end else if (gap_r) begin
            gap_nxt = 1'b0;
          end else begin
            pat_nxt = pat_r >> 1;
            rem_nxt = rem_r - 1'b1;
            gap_nxt = (rem_r > LEN_W'(1));
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the output register until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (gen) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      dot_r         <= DOT_TICKS_RST;
      cnt_r         <= '0;
      single_r      <= 1'b0;
      single_kind_r <= SEG_WORD_GAP;
      gap_r         <= 1'b0;
      rem_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      single_r      <= single_nxt;
      single_kind_r <= single_kind_nxt;
      gap_r         <= gap_nxt;
      rem_r         <= rem_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        dot_r <= cfg_ch.data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
    if (gen) begin
      kind_r   <= seg_kind;
      key_on_r <= (seg_kind == SEG_DOT) || (seg_kind == SEG_DASH);
      dur_r    <= seg_dur;
      shown_r  <= shown;
      last_r   <= seg_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.segment_kind   = kind_r;
  assign out_ch.key_on         = key_on_r;
  assign out_ch.duration_ticks = dur_r;
  assign out_ch.unsent_count   = shown_r;
  assign out_ch.last           = last_r;

endmodule

/* design/mks_checker.sv */
// Port-level checker for the Morse keying sequencer, bound to the top level.
// Depends on mks_pkg for widths and segment kinds.

module mks_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mks_pkg::KIND_W-1:0] out_kind,
  input logic                       out_key_on,
  input logic [mks_pkg::DUR_W-1:0]  out_dur,
  input logic                       out_last
);
  import mks_pkg::*;

  // Not ready again in the cycle after taking a character.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // A non-final segment waiting means the character is still in progress.
  a_busy_mid_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while a character is unfinished");

  // Tone only on dots and dashes.
  a_key_on_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_on == ((out_kind == SEG_DOT) || (out_kind == SEG_DASH))))
    else $error("key_on does not match segment kind");

  // Every character ends in a silent gap.
  a_last_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_key_on)
    else $error("final segment keyed on");

  // Stalled segment holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_dur)
      && $stable(out_last))
    else $error("stalled segment changed");

endmodule

bind morse_keying_sequencer_top mks_checker u_mks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.segment_kind),
  .out_key_on (out_ch.key_on),
  .out_dur    (out_ch.duration_ticks),
  .out_last   (out_ch.last)
);
